// ----- rtl/core/geq_pkg.sv -----
// Shared types, constants and helpers of the ten-band graphic equalizer.
package geq_pkg;

  localparam int CHANNELS = 6;
  localparam int BANDS    = 10;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // item kinds carried in func
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_COEF   = 2'd1;
  localparam logic [1:0] FUNC_GAIN   = 2'd2;

  // coefficient selectors
  localparam logic [1:0] SEL_A0 = 2'd0;
  localparam logic [1:0] SEL_A1 = 2'd1;
  localparam logic [1:0] SEL_B0 = 2'd2;

  // configuration register indexes
  localparam logic REG_ACTIVE_BANDS = 1'b0;

  // fixed b1 tap, -1.0050 in Q2.21
  localparam logic signed [23:0] B1_FIXED = -24'sd2107638;

  localparam logic signed [47:0] SAT40_MAX = 48'sd549755813887;
  localparam logic signed [47:0] SAT40_MIN = -48'sd549755813888;

  // one beat travelling down the band chain
  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         channel;
    logic [3:0]         band;
    logic [1:0]         coef_sel;
    logic signed [23:0] value;
    logic signed [39:0] y;
  } item_t;

  function automatic logic signed [39:0] sat40(input logic signed [47:0] x);
    logic signed [39:0] r;
    if (x > SAT40_MAX) r = SAT40_MAX[39:0];
    else if (x < SAT40_MIN) r = SAT40_MIN[39:0];
    else r = x[39:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/geq_cell.sv -----
// One band section: coefficients, per-channel gain and delay line, shared multiplier.
module geq_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic [3:0]      band_idx,
  input  logic            band_on,
  input  logic            in_valid,
  output logic            in_ready,
  input  geq_pkg::item_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output geq_pkg::item_t  out_item
);

  geq_pkg::item_t item;
  logic full, busy;
  logic [2:0] pidx;
  logic [1:0] phase;

  logic signed [23:0] a0, a1, b0;
  logic signed [23:0] gain [geq_pkg::CHANNELS];
  logic signed [39:0] drec [geq_pkg::CHANNELS];
  logic signed [39:0] dold [geq_pkg::CHANNELS];

  logic signed [44:0] mlo;
  logic signed [43:0] mhi;
  logic signed [47:0] acc;
  logic signed [39:0] w, v;

  logic [geq_pkg::CH_IDX_W-1:0] ch, in_ch;
  logic signed [39:0] d1, d2, opa, ynew;
  logic signed [23:0] opc;
  logic signed [63:0] prod;
  logic signed [47:0] fl;
  logic in_acc, out_acc, in_ch_ok;

  assign ch      = item.channel[geq_pkg::CH_IDX_W-1:0];
  assign in_ch   = in_item.channel[geq_pkg::CH_IDX_W-1:0];
  assign in_ch_ok = {1'b0, in_item.channel} < 4'(geq_pkg::CHANNELS);
  assign d1      = drec[ch];
  assign d2      = dold[ch];
  assign in_ready  = !full;
  assign out_valid = full && !busy;
  assign out_item  = item;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // operand pair of the current product
  always_comb begin
    case (pidx)
      3'd0: begin opa = item.y; opc = b0; end
      3'd1: begin opa = d1;     opc = a0; end
      3'd2: begin opa = d2;     opc = a1; end
      3'd3: begin opa = d2;     opc = geq_pkg::B1_FIXED; end
      3'd4: begin opa = v;      opc = gain[ch]; end
      default: begin opa = '0;  opc = '0; end
    endcase
  end

  // recombine partial products, floor shift by 21
  always_comb begin
    prod = (64'(mhi) <<< 20) + 64'(mlo);
    fl   = 48'(prod >>> 21);
    ynew = geq_pkg::sat40(48'(item.y) + fl);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= 1'b0;
      busy  <= 1'b0;
      pidx  <= '0;
      phase <= '0;
    end else begin
      if (in_acc) begin
        full  <= 1'b1;
        busy  <= (in_item.func == geq_pkg::FUNC_SAMPLE) && band_on;
        pidx  <= '0;
        phase <= '0;
      end else if (busy) begin
        if (phase == 2'd2) begin
          phase <= '0;
          pidx  <= pidx + 3'd1;
          if (pidx == 3'd4) busy <= 1'b0;
        end else begin
          phase <= phase + 2'd1;
        end
      end else if (out_acc) begin
        full <= 1'b0;
      end
    end
  end

  // band coefficients and gains, written as write beats pass
  always_ff @(posedge clk) begin
    if (rst) begin
      a0 <= '0;
      a1 <= '0;
      b0 <= '0;
      for (int i = 0; i < geq_pkg::CHANNELS; i++) gain[i] <= '0;
    end else if (in_acc && in_item.band == band_idx) begin
      if (in_item.func == geq_pkg::FUNC_COEF) begin
        case (in_item.coef_sel)
          geq_pkg::SEL_A0: a0 <= in_item.value;
          geq_pkg::SEL_A1: a1 <= in_item.value;
          geq_pkg::SEL_B0: b0 <= in_item.value;
          default: ;
        endcase
      end else if (in_item.func == geq_pkg::FUNC_GAIN && in_ch_ok) begin
        gain[in_ch] <= in_item.value;
      end
    end
  end

  // delay line per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < geq_pkg::CHANNELS; i++) begin
        drec[i] <= '0;
        dold[i] <= '0;
      end
    end else if (busy && phase == 2'd2 && pidx == 3'd4) begin
      dold[ch] <= d1;
      drec[ch] <= w;
    end
  end

  // datapath: low half, high half, combine and accumulate
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item <= in_item;
    end else if (busy) begin
      case (phase)
        2'd0: mlo <= $signed({1'b0, opa[19:0]}) * opc;
        2'd1: mhi <= $signed(opa[39:20]) * opc;
        default: begin
          case (pidx)
            3'd0: acc <= fl;
            3'd1: acc <= acc + fl;
            3'd2: w   <= geq_pkg::sat40(acc + fl);
            3'd3: v   <= geq_pkg::sat40(48'(w) + fl);
            default: item.y <= ynew;
          endcase
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/geq_out.sv -----
// Output scaling: divide by 40 * 2^21 toward zero, saturate, register the beat.
module geq_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  geq_pkg::item_t  in_item,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [23:0]     m_tdata,   // out_sample[15:0], out_channel[18:16], zero pad
  output logic            m_tuser    // clipped
);

  logic        s1v, s1neg;
  logic [15:0] s1m;
  logic [2:0]  s1ch;
  logic        s1_ready, s2_ready;
  logic [39:0] mag;
  logic [32:0] recip;
  logic signed [16:0] q;
  logic signed [15:0] osample;
  logic        oclip;
  logic [2:0]  och;

  assign s2_ready = !m_tvalid || m_tready;
  assign s1_ready = !s1v || s2_ready;
  assign in_ready = s1_ready;
  assign mag = in_item.y[39] ? 40'(-in_item.y) : 40'(in_item.y);

  // floor(m / 5) by reciprocal, exact for 16-bit m
  always_comb begin
    recip = 33'(s1m) * 33'd52429;
    q = s1neg ? -17'(recip[32:18]) : 17'(recip[32:18]);
  end

  // first stage: magnitude over 2^24
  always_ff @(posedge clk) begin
    if (rst) s1v <= 1'b0;
    else if (s1_ready) s1v <= in_valid && in_item.func == geq_pkg::FUNC_SAMPLE;
  end
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1m   <= mag[39:24];
      s1neg <= in_item.y[39];
      s1ch  <= in_item.channel;
    end
  end

  // second stage: result register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (s2_ready) m_tvalid <= s1v;
  end
  always_ff @(posedge clk) begin
    if (s2_ready && s1v) begin
      och <= s1ch;
      if (q > 17'sd32767) begin
        osample <= 16'sh7FFF; oclip <= 1'b1;
      end else if (q < -17'sd32768) begin
        osample <= 16'sh8000; oclip <= 1'b1;
      end else begin
        osample <= q[15:0];   oclip <= 1'b0;
      end
    end
  end

  assign m_tdata = {5'd0, och, osample};
  assign m_tuser = oclip;

endmodule

// ----- rtl/core/ten_band_graphic_equalizer_top.sv -----
// Top level of the multichannel ten-band graphic equalizer.
// Beats run down a chain of band cells, one per band, then an output scaler.
// In each active band cell a sample takes five 40x24 products, each taken as two
// partial products and a combine on the cell's own multiplier, plus the handoff;
// an inactive cell passes it on without computing. A cell takes a new beat in the
// cycle after it hands one on and none before, so a new sample enters the chain
// only once the first cell has handed the one before on. Coefficient and gain
// writes give no result, as do samples of a nonexistent channel and func 3,
// which are dropped at the input.
module ten_band_graphic_equalizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // channel[2:0], band[6:3], coef_sel[8:7], value[32:9], in_sample[48:33], zero pad
  input  logic [55:0] s_tdata,
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_sample[15:0], out_channel[18:16], zero pad
  output logic        m_tuser,   // clipped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int B = geq_pkg::BANDS;

  logic [3:0] active_bands, nb;
  geq_pkg::item_t entry, items [B+1];
  logic vld [B+1];
  logic rdy [B+1];
  logic keep, ch_ok;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) active_bands <= 4'd10;
    else if (psel && penable && pwrite && paddr[2] == geq_pkg::REG_ACTIVE_BANDS)
      active_bands <= pwdata[3:0];
  end
  assign prdata = (paddr[2] == geq_pkg::REG_ACTIVE_BANDS) ? {28'd0, active_bands} : 32'd0;
  assign nb = (active_bands > 4'(B)) ? 4'(B) : active_bands;

  // input unpack and filter
  assign ch_ok = {1'b0, s_tdata[2:0]} < 4'(geq_pkg::CHANNELS);
  assign keep = (s_tuser == geq_pkg::FUNC_SAMPLE && ch_ok) ||
                s_tuser == geq_pkg::FUNC_COEF || s_tuser == geq_pkg::FUNC_GAIN;
  always_comb begin
    entry.func     = s_tuser;
    entry.channel  = s_tdata[2:0];
    entry.band     = s_tdata[6:3];
    entry.coef_sel = s_tdata[8:7];
    entry.value    = $signed(s_tdata[32:9]);
    entry.y        = {{3{s_tdata[48]}}, s_tdata[48:33], 21'd0};
  end
  assign items[0] = entry;
  assign vld[0]   = s_tvalid && keep;
  assign s_tready = rdy[0] || !keep;

  // band chain
  for (genvar k = 0; k < B; k++) begin : g_band
    geq_cell u_cell (
      .clk(clk), .rst(rst),
      .band_idx(4'(k)),
      .band_on(4'(k) < nb),
      .in_valid(vld[k]), .in_ready(rdy[k]), .in_item(items[k]),
      .out_valid(vld[k+1]), .out_ready(rdy[k+1]), .out_item(items[k+1])
    );
  end

  geq_out u_out (
    .clk(clk), .rst(rst),
    .in_valid(vld[B]), .in_ready(rdy[B]), .in_item(items[B]),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

// ----- rtl/core/geq_chk.sv -----
// Port-level checks of the equalizer top, bound to it.
module geq_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        pready
);

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // clip flag only with a saturated sample
  a_clip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:0] == 16'h7FFF || m_tdata[15:0] == 16'h8000)
    else $error("clip flag without saturated sample");

  // channel in range, padding zero
  a_chan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18:16] < 3'd6 && m_tdata[23:19] == 5'd0)
    else $error("bad result channel or padding");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind ten_band_graphic_equalizer_top geq_chk u_geq_chk (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .pready(pready)
);

// ----- sim/tb.sv -----
// Self-checking testbench for the ten-band graphic equalizer top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         channel;
    logic [3:0]         band;
    logic [1:0]         coef_sel;
    logic signed [23:0] value;
    logic signed [15:0] in_sample;
  } eq_req_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic [2:0]         out_channel;
    logic               clipped;
  } eq_res_t;

  localparam logic [1:0] FUNC_BAD = 2'd3;
  localparam logic [1:0] SEL_BAD  = 2'd3;
  localparam logic [2:0] ADDR_ACTIVE_BANDS = 3'd0;
  localparam logic signed [63:0] DIVISOR = 64'sd83886080;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ten_band_graphic_equalizer_top dut (.*);

  always #5 clk = ~clk;

  // predictor state
  int unsigned        eq_bands;
  logic signed [23:0] a_one [geq_pkg::BANDS];
  logic signed [23:0] a_two [geq_pkg::BANDS];
  logic signed [23:0] b_zero [geq_pkg::BANDS];
  logic signed [23:0] gain_tab [geq_pkg::CHANNELS][geq_pkg::BANDS];
  logic signed [39:0] d_recent [geq_pkg::CHANNELS][geq_pkg::BANDS];
  logic signed [39:0] d_older [geq_pkg::CHANNELS][geq_pkg::BANDS];

  eq_req_t req_q[$];
  eq_res_t expected_q[$];
  int      errors = 0;
  longint  cycles = 0;

  function automatic logic signed [63:0] shr_floor(input logic signed [63:0] p);
    return p >>> 21;
  endfunction

  function automatic logic signed [63:0] clamp40(input logic signed [63:0] x);
    if (x > 64'sd549755813887) return 64'sd549755813887;
    if (x < -64'sd549755813888) return -64'sd549755813888;
    return x;
  endfunction

  // apply one item to the predictor, queueing any result it produces
  task automatic predict_item(input eq_req_t r);
    logic signed [63:0] y, w, v, d1, d2, q;
    int unsigned nb;
    eq_res_t res;
    if (r.func == geq_pkg::FUNC_COEF) begin
      if (r.band < geq_pkg::BANDS) begin
        if (r.coef_sel == geq_pkg::SEL_A0) a_one[r.band] = r.value;
        else if (r.coef_sel == geq_pkg::SEL_A1) a_two[r.band] = r.value;
        else if (r.coef_sel == geq_pkg::SEL_B0) b_zero[r.band] = r.value;
      end
    end else if (r.func == geq_pkg::FUNC_GAIN) begin
      if (r.channel < geq_pkg::CHANNELS && r.band < geq_pkg::BANDS)
        gain_tab[r.channel][r.band] = r.value;
    end else if (r.func == geq_pkg::FUNC_SAMPLE && r.channel < geq_pkg::CHANNELS) begin
      nb = (eq_bands > geq_pkg::BANDS) ? geq_pkg::BANDS : eq_bands;
      y = 64'(r.in_sample) <<< 21;
      for (int k = 0; k < nb; k++) begin
        d1 = d_recent[r.channel][k];
        d2 = d_older[r.channel][k];
        w = clamp40(shr_floor(y * b_zero[k]) + shr_floor(d1 * a_one[k])
                    + shr_floor(d2 * a_two[k]));
        v = clamp40(w + shr_floor(d2 * geq_pkg::B1_FIXED));
        y = clamp40(y + shr_floor(v * gain_tab[r.channel][k]));
        d_older[r.channel][k] = d1[39:0];
        d_recent[r.channel][k] = w[39:0];
      end
      q = y / DIVISOR;
      res.clipped = 1'b0;
      if (q > 32767) begin
        q = 32767;
        res.clipped = 1'b1;
      end else if (q < -32768) begin
        q = -32768;
        res.clipped = 1'b1;
      end
      res.out_sample = q[15:0];
      res.out_channel = r.channel;
      expected_q.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_item(req_q.pop_front());
      end
      if (!s_tvalid || s_tready) begin
        if (s_tvalid && s_tready) src_gap = gap_len();
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tuser <= req_q[0].func;
          s_tdata <= {7'd0, req_q[0].in_sample, req_q[0].value, req_q[0].coef_sel,
                      req_q[0].band, req_q[0].channel};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and sink stall
  int sink_gap = 0;
  always @(posedge clk) begin
    eq_res_t want;
    if (!rst) begin
      cycles++;
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", 32'(m_tdata), 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[15:0] !== want.out_sample)
            report_mismatch("out_sample", 32'(m_tdata[15:0]), 32'(want.out_sample));
          if (m_tdata[18:16] !== want.out_channel)
            report_mismatch("out_channel", 32'(m_tdata[18:16]), 32'(want.out_channel));
          if (m_tuser !== want.clipped)
            report_mismatch("clipped", 32'(m_tuser), 32'(want.clipped));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_gap = gap_len();
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic eq_req_t mk(input logic [1:0] f, input logic [2:0] c,
                                 input logic [3:0] b, input logic [1:0] s,
                                 input logic [23:0] v, input logic [15:0] x);
    eq_req_t r;
    r.func = f; r.channel = c; r.band = b; r.coef_sel = s; r.value = v; r.in_sample = x;
    return r;
  endfunction

  function automatic eq_req_t rand_sample();
    logic [15:0] x;
    case ($urandom_range(0, 5))
      0: x = 16'h7fff;
      1: x = 16'h8000;
      default: x = 16'($urandom());
    endcase
    return mk(geq_pkg::FUNC_SAMPLE, 3'($urandom_range(0, geq_pkg::CHANNELS - 1)),
              4'($urandom()), 2'($urandom()), 24'($urandom()), x);
  endfunction

  // small stable-ish coefficients mostly, full-range now and then
  function automatic logic [23:0] rand_value();
    if ($urandom_range(0, 9) == 0) return 24'($urandom());
    return 24'($signed($urandom_range(0, 1048575)) - 524288);
  endfunction

  task automatic wait_drained();
    while (req_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_bands(input logic [31:0] n);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_ACTIVE_BANDS; pwdata <= n;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    eq_bands = n[3:0];
  endtask

  initial begin
    int unsigned band_set [6] = '{0, 15, 1, 10, 5, 3};
    eq_bands = 10;
    foreach (a_one[k]) begin
      a_one[k] = '0; a_two[k] = '0; b_zero[k] = '0;
    end
    foreach (gain_tab[c, k]) begin
      gain_tab[c][k] = '0; d_recent[c][k] = '0; d_older[c][k] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: samples at unity, coefficient and gain writes incl. ignored ones, odd items
    req_q.push_back(mk(geq_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 16'h7fff));
    req_q.push_back(mk(geq_pkg::FUNC_SAMPLE, 5, 0, 0, 0, 16'h8000));
    req_q.push_back(mk(geq_pkg::FUNC_SAMPLE, 6, 0, 0, 0, 16'h1234));
    req_q.push_back(mk(geq_pkg::FUNC_SAMPLE, 7, 0, 0, 0, 16'h1234));
    req_q.push_back(mk(FUNC_BAD, 0, 0, 0, 0, 16'h1111));
    req_q.push_back(mk(geq_pkg::FUNC_COEF, 0, 0, geq_pkg::SEL_A0, 24'h7fffff, 0));
    req_q.push_back(mk(geq_pkg::FUNC_COEF, 0, 9, geq_pkg::SEL_A1, 24'h800000, 0));
    req_q.push_back(mk(geq_pkg::FUNC_COEF, 0, 3, geq_pkg::SEL_B0, 24'h200000, 0));
    req_q.push_back(mk(geq_pkg::FUNC_COEF, 0, 10, geq_pkg::SEL_B0, 24'h100000, 0));
    req_q.push_back(mk(geq_pkg::FUNC_COEF, 0, 15, geq_pkg::SEL_A0, 24'h100000, 0));
    req_q.push_back(mk(geq_pkg::FUNC_COEF, 0, 2, SEL_BAD, 24'h100000, 0));
    req_q.push_back(mk(geq_pkg::FUNC_GAIN, 0, 3, 0, 24'h7fffff, 0));
    req_q.push_back(mk(geq_pkg::FUNC_GAIN, 5, 0, 0, 24'h800000, 0));
    req_q.push_back(mk(geq_pkg::FUNC_GAIN, 6, 1, 0, 24'h100000, 0));
    req_q.push_back(mk(geq_pkg::FUNC_GAIN, 1, 12, 0, 24'h100000, 0));
    for (int i = 0; i < 6; i++) req_q.push_back(mk(geq_pkg::FUNC_SAMPLE, i % 2 ? 5 : 0,
                                                   0, 0, 0, i % 2 ? 16'h8000 : 16'h7fff));
    wait_drained();

    // random phases over several band counts
    foreach (band_set[p]) begin
      write_bands(band_set[p]);
      for (int i = 0; i < 300; i++) begin
        case ($urandom_range(0, 19))
          0, 1: req_q.push_back(mk(geq_pkg::FUNC_COEF, 3'($urandom()),
                                   4'($urandom_range(0, 11)), 2'($urandom()),
                                   rand_value(), 16'($urandom())));
          2, 3: req_q.push_back(mk(geq_pkg::FUNC_GAIN, 3'($urandom()),
                                   4'($urandom_range(0, 11)), 2'($urandom()),
                                   rand_value(), 16'($urandom())));
          4: req_q.push_back(mk(2'($urandom()), 3'($urandom()), 4'($urandom()),
                                2'($urandom()), 24'($urandom()), 16'($urandom())));
          default: req_q.push_back(rand_sample());
        endcase
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
